// ----- hdl/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types for the double-ended queue: command and status codes,
// controller states and the control/status bundles between the FSM and the
// datapath.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int DATA_W = 32;
	localparam int OP_W = 3;
	localparam int STATUS_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_LIST_FWD   = 3'd2,
		OP_LIST_BWD   = 3'd3,
		OP_POP_FRONT  = 3'd4,
		OP_POP_BACK   = 3'd5
	} deq_op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_OVERFLOW  = 2'd2,
		ST_EMPTY     = 2'd3
	} deq_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP_LD,
		S_LIST_RD,
		S_LIST_LD,
		S_OUT
	} deq_state_t;

	typedef struct packed {
		logic        push;
		logic        pop;
		logic        at_back;
		logic        list_start;
		logic        list_step;
		logic        load;
		logic        load_mem;
		deq_status_t status;
		logic        last;
	} deq_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic list_done;
		logic out_last;
	} deq_stat_t;

endpackage

// ----- hdl/deq_ctrl.sv -----
// ----------------------------------------------------------------------------
// deq_ctrl
// Controller FSM: decodes each request, sequences pops and listings through
// the datapath and holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
module deq_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [2:0]                   command,
	output logic                         out_valid,
	input  logic                         out_ready,
	input  deq_pkg::deq_stat_t           dp_stat,
	output deq_pkg::deq_cmd_t            dp_cmd
);
	import deq_pkg::*;

	deq_state_t state_q;
	deq_state_t state_next;
	deq_op_t    op;

	assign op = deq_op_t'(command);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		dp_cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (op)
						OP_PUSH_FRONT, OP_PUSH_BACK: begin
							dp_cmd.at_back = (op == OP_PUSH_BACK);
							dp_cmd.load = 1'b1;
							dp_cmd.last = 1'b1;
							if (dp_stat.full) begin
								dp_cmd.status = ST_OVERFLOW;
							end else begin
								dp_cmd.push = 1'b1;
								dp_cmd.status = ST_OK;
							end
							state_next = S_OUT;
						end
						OP_POP_FRONT, OP_POP_BACK: begin
							dp_cmd.at_back = (op == OP_POP_BACK);
							if (dp_stat.empty) begin
								dp_cmd.load = 1'b1;
								dp_cmd.status = ST_UNDERFLOW;
								dp_cmd.last = 1'b1;
								state_next = S_OUT;
							end else begin
								dp_cmd.pop = 1'b1;
								state_next = S_POP_LD;
							end
						end
						OP_LIST_FWD, OP_LIST_BWD: begin
							dp_cmd.at_back = (op == OP_LIST_BWD);
							if (dp_stat.empty) begin
								dp_cmd.load = 1'b1;
								dp_cmd.status = ST_EMPTY;
								dp_cmd.last = 1'b1;
								state_next = S_OUT;
							end else begin
								dp_cmd.list_start = 1'b1;
								state_next = S_LIST_RD;
							end
						end
						default: begin
							state_next = S_IDLE;
						end
					endcase
				end
			end
			S_POP_LD: begin
				dp_cmd.load = 1'b1;
				dp_cmd.load_mem = 1'b1;
				dp_cmd.status = ST_OK;
				dp_cmd.last = 1'b1;
				state_next = S_OUT;
			end
			S_LIST_RD: begin
				dp_cmd.list_step = 1'b1;
				state_next = S_LIST_LD;
			end
			S_LIST_LD: begin
				dp_cmd.load = 1'b1;
				dp_cmd.load_mem = 1'b1;
				dp_cmd.status = ST_OK;
				dp_cmd.last = dp_stat.list_done;
				state_next = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_next = dp_stat.out_last ? S_IDLE : S_LIST_RD;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

endmodule

// ----- hdl/deq_dpath.sv -----
// ----------------------------------------------------------------------------
// deq_dpath
// Datapath: ring-buffer storage, front/back pointers, entry count, listing
// cursor and the result register.
// ----------------------------------------------------------------------------
module deq_dpath #(
	parameter int DEPTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic signed [31:0]           value,
	input  deq_pkg::deq_cmd_t            dp_cmd,
	output deq_pkg::deq_stat_t           dp_stat,
	output logic signed [31:0]           data,
	output logic [1:0]                   status,
	output logic                         last
);
	import deq_pkg::*;

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] IDX_MAX = IW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	logic [IW-1:0] front_q;
	logic [IW-1:0] back_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] cursor_q;
	logic [CW-1:0] remain_q;
	logic          dir_back_q;

	logic signed [31:0] data_q;
	deq_status_t        status_q;
	logic               last_q;

	logic [IW-1:0] front_dec;
	logic [IW-1:0] back_inc;
	logic [IW-1:0] front_inc;
	logic [IW-1:0] back_dec;
	logic [IW-1:0] cursor_next;
	logic [IW-1:0] wr_addr;
	logic [IW-1:0] rd_addr;
	logic          wr_en;
	logic          is_empty;

	assign is_empty = (count_q == '0);

	assign front_dec = (front_q == '0) ? IDX_MAX : front_q - 1'b1;
	assign front_inc = (front_q == IDX_MAX) ? '0 : front_q + 1'b1;
	assign back_dec  = (back_q == '0) ? IDX_MAX : back_q - 1'b1;
	assign back_inc  = (back_q == IDX_MAX) ? '0 : back_q + 1'b1;

	always_comb begin
		if (dir_back_q) begin
			cursor_next = (cursor_q == '0) ? IDX_MAX : cursor_q - 1'b1;
		end else begin
			cursor_next = (cursor_q == IDX_MAX) ? '0 : cursor_q + 1'b1;
		end
	end

	always_comb begin
		wr_en = dp_cmd.push;
		if (is_empty) begin
			wr_addr = front_q;
		end else if (dp_cmd.at_back) begin
			wr_addr = back_inc;
		end else begin
			wr_addr = front_dec;
		end
	end

	always_comb begin
		if (dp_cmd.list_step) begin
			rd_addr = cursor_q;
		end else if (dp_cmd.at_back) begin
			rd_addr = back_q;
		end else begin
			rd_addr = front_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= value;
		end
		rdata_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q <= '0;
			count_q <= '0;
		end else if (dp_cmd.push) begin
			count_q <= count_q + 1'b1;
			if (is_empty) begin
				back_q <= front_q;
			end else if (dp_cmd.at_back) begin
				back_q <= back_inc;
			end else begin
				front_q <= front_dec;
			end
		end else if (dp_cmd.pop) begin
			count_q <= count_q - 1'b1;
			if (count_q == CW'(1)) begin
				back_q <= front_q;
			end else if (dp_cmd.at_back) begin
				back_q <= back_dec;
			end else begin
				front_q <= front_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remain_q <= '0;
			dir_back_q <= 1'b0;
		end else if (dp_cmd.list_start) begin
			remain_q <= count_q;
			dir_back_q <= dp_cmd.at_back;
		end else if (dp_cmd.list_step) begin
			remain_q <= remain_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.list_start) begin
			cursor_q <= dp_cmd.at_back ? back_q : front_q;
		end else if (dp_cmd.list_step) begin
			cursor_q <= cursor_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b1;
		end else if (dp_cmd.load) begin
			last_q <= dp_cmd.last;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			data_q <= dp_cmd.load_mem ? signed'(rdata_q) : '0;
			status_q <= dp_cmd.status;
		end
	end

	assign dp_stat.empty = is_empty;
	assign dp_stat.full = (count_q == CNT_FULL);
	assign dp_stat.list_done = (remain_q == '0);
	assign dp_stat.out_last = last_q;

	assign data = data_q;
	assign status = status_q;
	assign last = last_q;

endmodule

// ----- hdl/double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed 32-bit values kept in a ring buffer.
//
// Input channel (in_valid/in_ready): command and value. Push front/back,
// pop front/back, list front-to-back or back-to-front. Codes 6 and 7 are
// taken and dropped without a result.
// Output channel (out_valid/out_ready): data, status, last. Every request
// but a non-empty listing gives one result with last set; a listing gives
// one result per stored entry, last set on the final one.
// One request at a time: in_ready is high only while no result is pending.
// Push, underflow and empty listing: result valid in the cycle after the accept.
// Pop: the accept starts a registered memory read, S_POP_LD loads the result
// register, then S_OUT presents it. Listing: each entry passes S_LIST_RD
// (memory read) and S_LIST_LD (load) before the output handshake in S_OUT.
// A stalled receiver holds the result register and the controller.
// Reset empties the queue; no clearing pass runs over the storage.
// ----------------------------------------------------------------------------
module double_ended_queue #(
	parameter int DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         command,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] data,
	output logic [1:0]         status,
	output logic               last
);
	import deq_pkg::*;

	deq_cmd_t  dp_cmd;
	deq_stat_t dp_stat;

	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dp_stat   (dp_stat),
		.dp_cmd    (dp_cmd)
	);

	deq_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.value   (value),
		.dp_cmd  (dp_cmd),
		.dp_stat (dp_stat),
		.data    (data),
		.status  (status),
		.last    (last)
	);

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("request accepted while a result is pending");

	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> last)
		else $error("error result without last");

	a_push_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (command == OP_PUSH_FRONT || command == OP_PUSH_BACK))
		|=> (out_valid && last))
		else $error("push result not presented in the next cycle");

	a_list_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last) |=> !in_ready)
		else $error("listing ended before its last entry");

endmodule
